@@ design/olst_pkg.sv @@
// ----------------------------------------------------------------------------
// olst_pkg
// Shared constants, command and status codes, and cell control for the
// ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

   localparam int CELL_COUNT  = 16;
   localparam int LEN_BITS    = $clog2(CELL_COUNT + 1);
   localparam int VALUE_BITS  = 32;
   localparam int KIND_BITS   = 3;
   localparam int POS_BITS    = 8;
   localparam int STATUS_BITS = 3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_INS_FRONT = 3'd0,
      KIND_APPEND    = 3'd1,
      KIND_INS_POS   = 3'd2,
      KIND_REM_FRONT = 3'd3,
      KIND_REM_VALUE = 3'd4
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_POS   = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_MATCH,
      STATE_APPLY
   } state_type;

   typedef struct packed {
      logic compare;
      logic load;
      logic take_prev;
      logic take_next;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ design/olst_cell.sv @@
// ----------------------------------------------------------------------------
// olst_cell
// One list slot: holds a value, compares it with the command value and
// loads, shifts from its left or right neighbor under control.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_cell
   import olst_pkg::*;
(
   input  wire logic                  clock,
   input  wire cell_ctl_type          ctl,
   input  wire logic [VALUE_BITS-1:0] cmd_value,
   input  wire logic [VALUE_BITS-1:0] prev_value,
   input  wire logic [VALUE_BITS-1:0] next_value,
   output logic      [VALUE_BITS-1:0] value_out,
   output logic                       match_out
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = cmd_value;
      end else if (ctl.take_prev) begin
         value_in = prev_value;
      end else if (ctl.take_next) begin
         value_in = next_value;
      end
      match_in = ctl.compare ? (value_ff == cmd_value) : match_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value_out = value_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

@@ design/ordered_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low; req_kind
//   selects insert front, append, insert at 1-based position, remove front
//   or remove first equal value.
//   Every command gives one result beat: rsp_valid is high for one cycle
//   with rsp_status, rsp_removed_value and rsp_list_length.
//   Each command passes through accept, cell compare and cell shift before
//   its result is shown. Busy is high in the compare and shift states
//   after accept, so a new command is not taken while one is in flight;
//   the compare pass over all cells followed by the shift pass sets this.
//   The next command may be taken in the cycle the result is shown.
//   Reset empties the list and clears the response strobe; it takes
//   effect at once with no clearing pass.
//   The receiver cannot stall: each result beat is taken in its cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_core
   import olst_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic        [KIND_BITS-1:0]   req_kind,
   input  wire logic        [POS_BITS-1:0]    req_position,
   input  wire logic signed [VALUE_BITS-1:0]  req_item_value,
   output logic                               rsp_valid,
   output logic             [STATUS_BITS-1:0] rsp_status,
   output logic signed      [VALUE_BITS-1:0]  rsp_removed_value,
   output logic             [LEN_BITS-1:0]    rsp_list_length
);

   state_type             state_ff, state_in;
   logic [KIND_BITS-1:0]  kind_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [VALUE_BITS-1:0] cmd_value_ff;
   logic [LEN_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_removed_ff, rsp_removed_in;

   logic                  accept;
   logic                  compare_en;
   logic                  apply_en;

   logic [VALUE_BITS-1:0] cell_value [CELL_COUNT];
   logic [VALUE_BITS-1:0] prev_value [CELL_COUNT];
   logic [VALUE_BITS-1:0] next_value [CELL_COUNT];
   logic [CELL_COUNT-1:0] cell_match;
   cell_ctl_type          cell_ctl   [CELL_COUNT];

   logic [CELL_COUNT-1:0] hit;
   logic [CELL_COUNT-1:0] upto;
   logic [CELL_COUNT-1:0] first;
   logic [VALUE_BITS-1:0] found_value;
   logic [POS_BITS-1:0]   pos_m1;
   logic [LEN_BITS-1:0]   ins_idx;
   logic                  do_insert;
   logic                  do_remove;
   logic [CELL_COUNT-1:0] shift_mask;

   assign accept = start & ~busy;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE:  if (start) begin
            state_in = STATE_MATCH;
         end
         STATE_MATCH: state_in = STATE_APPLY;
         STATE_APPLY: state_in = STATE_IDLE;
         default:     state_in = STATE_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      compare_en = 1'b0;
      apply_en   = 1'b0;
      case (state_ff)
         STATE_IDLE:  busy = 1'b0;
         STATE_MATCH: compare_en = 1'b1;
         STATE_APPLY: apply_en = 1'b1;
         default:     busy = 1'b1;
      endcase
   end

   // first match among the occupied cells
   always_comb begin
      found_value = '0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         hit[i] = cell_match[i] & (LEN_BITS'(i) < count_ff);
      end
      for (int i = 0; i < CELL_COUNT; i++) begin
         upto[i] = 1'b0;
         for (int j = 0; j < CELL_COUNT; j++) begin
            if (j <= i) begin
               upto[i] = upto[i] | hit[j];
            end
         end
      end
      first[0] = upto[0];
      for (int i = 1; i < CELL_COUNT; i++) begin
         first[i] = upto[i] & ~upto[i-1];
      end
      for (int i = 0; i < CELL_COUNT; i++) begin
         found_value = found_value | ({VALUE_BITS{first[i]}} & cell_value[i]);
      end
   end

   // command decode
   always_comb begin
      pos_m1         = pos_ff - POS_BITS'(1);
      ins_idx        = '0;
      do_insert      = 1'b0;
      do_remove      = 1'b0;
      shift_mask     = '0;
      count_in       = count_ff;
      rsp_status_in  = STATUS_OK;
      rsp_removed_in = '0;
      case (kind_type'(kind_ff))
         KIND_INS_FRONT, KIND_APPEND, KIND_INS_POS: begin
            if (kind_type'(kind_ff) == KIND_INS_POS && pos_ff == '0) begin
               rsp_status_in = STATUS_BAD_POS;
            end else if (count_ff == LEN_BITS'(CELL_COUNT)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + LEN_BITS'(1);
               if (kind_type'(kind_ff) == KIND_INS_FRONT) begin
                  ins_idx = '0;
               end else if (kind_type'(kind_ff) == KIND_APPEND) begin
                  ins_idx = count_ff;
               end else if (pos_m1 < POS_BITS'(count_ff)) begin
                  ins_idx = pos_m1[LEN_BITS-1:0];
               end else begin
                  ins_idx = count_ff;
               end
            end
         end
         KIND_REM_FRONT: begin
            if (count_ff == '0) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               do_remove      = 1'b1;
               shift_mask     = '1;
               count_in       = count_ff - LEN_BITS'(1);
               rsp_removed_in = cell_value[0];
            end
         end
         KIND_REM_VALUE: begin
            if (count_ff == '0) begin
               rsp_status_in = STATUS_EMPTY;
            end else if (upto[CELL_COUNT-1] == 1'b0) begin
               rsp_status_in = STATUS_NOT_FOUND;
            end else begin
               do_remove      = 1'b1;
               shift_mask     = upto;
               count_in       = count_ff - LEN_BITS'(1);
               rsp_removed_in = found_value;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      rsp_valid_in = apply_en;
   end

   always_comb begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         cell_ctl[i].compare   = compare_en;
         cell_ctl[i].load      = apply_en & do_insert & (LEN_BITS'(i) == ins_idx);
         cell_ctl[i].take_prev = apply_en & do_insert & (LEN_BITS'(i) > ins_idx);
         cell_ctl[i].take_next = apply_en & do_remove & shift_mask[i];
      end
   end

   // cell chain
   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_value[g] = '0;
      end else begin : g_mid
         assign prev_value[g] = cell_value[g-1];
      end
      if (g == CELL_COUNT - 1) begin : g_tail
         assign next_value[g] = '0;
      end else begin : g_body
         assign next_value[g] = cell_value[g+1];
      end

      olst_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .cmd_value  (cmd_value_ff),
         .prev_value (prev_value[g]),
         .next_value (next_value[g]),
         .value_out  (cell_value[g]),
         .match_out  (cell_match[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_en) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_kind;
         pos_ff       <= req_position;
         cmd_value_ff <= req_item_value;
      end
      if (apply_en) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_removed_ff <= rsp_removed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_list_length   = count_ff;

endmodule

`default_nettype wire

@@ design/olst_checker.sv @@
// ----------------------------------------------------------------------------
// olst_checker
// Port-level checks of command and result timing, removed value and length.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_checker
   import olst_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic [STATUS_BITS-1:0] rsp_status,
   input wire logic [VALUE_BITS-1:0]  rsp_removed_value,
   input wire logic [LEN_BITS-1:0]    rsp_list_length
);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("no result beat three cycles after command");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after command accept");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_removed_value == '0)
      else $error("removed value nonzero on failed command");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_list_length <= LEN_BITS'(CELL_COUNT))
      else $error("list length above capacity");

endmodule

bind ordered_list_engine_core olst_checker u_olst_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_list_length   (rsp_list_length)
);

`default_nettype wire

@@ bench/ordered_list_engine_core_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_core_checker
// Watches the command and result channels of the ordered list engine. Each
// accepted command is run through a local copy of the list to give the
// expected status, removed value and length. Each result beat is compared
// with the oldest outstanding prediction. The count of outstanding
// predictions and the count of mismatches go to the testbench top.
// ----------------------------------------------------------------------------
module ordered_list_engine_core_checker
   import olst_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic        [KIND_BITS-1:0]   req_kind,
   input  wire logic        [POS_BITS-1:0]    req_position,
   input  wire logic signed [VALUE_BITS-1:0]  req_item_value,
   input  wire logic                          rsp_valid,
   input  wire logic        [STATUS_BITS-1:0] rsp_status,
   input  wire logic signed [VALUE_BITS-1:0]  rsp_removed_value,
   input  wire logic        [LEN_BITS-1:0]    rsp_list_length,
   output int                                 fail_count,
   output int                                 pending
);

   typedef struct packed {
      status_type              status;
      logic [VALUE_BITS-1:0]   removed;
      logic [LEN_BITS-1:0]     length;
   } outcome_type;

   logic [VALUE_BITS-1:0] list_entries[$];
   outcome_type           predicted_outcomes[$];
   int                    mismatches = 0;
   int                    outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   task automatic report(input string what);
      $display("checker: mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // runs one command on the local list and returns the result it gives
   function automatic outcome_type list_command(input logic [KIND_BITS-1:0]  kind,
                                                input logic [POS_BITS-1:0]   position,
                                                input logic [VALUE_BITS-1:0] value);
      outcome_type o;
      int          slot;
      bit          found;
      o.status  = STATUS_OK;
      o.removed = '0;
      found     = 1'b0;
      case (kind)
         KIND_INS_FRONT, KIND_APPEND, KIND_INS_POS: begin
            if (kind == KIND_INS_POS && position == '0) begin
               o.status = STATUS_BAD_POS;
            end else if (list_entries.size() >= CELL_COUNT) begin
               o.status = STATUS_FULL;
            end else begin
               if (kind == KIND_INS_FRONT) begin
                  slot = 0;
               end else if (kind == KIND_APPEND) begin
                  slot = list_entries.size();
               end else begin
                  slot = int'(position) - 1;
                  if (slot > list_entries.size())
                     slot = list_entries.size();
               end
               list_entries.insert(slot, value);
            end
         end
         KIND_REM_FRONT: begin
            if (list_entries.size() == 0)
               o.status = STATUS_EMPTY;
            else
               o.removed = list_entries.pop_front();
         end
         KIND_REM_VALUE: begin
            if (list_entries.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.status = STATUS_NOT_FOUND;
               for (int i = 0; i < list_entries.size(); i++) begin
                  if (!found && list_entries[i] == value) begin
                     found     = 1'b1;
                     o.removed = list_entries[i];
                     o.status  = STATUS_OK;
                     list_entries.delete(i);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      o.length = LEN_BITS'(list_entries.size());
      return o;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (predicted_outcomes.size() == 0) begin
               report("result beat with no command outstanding");
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, predicted %0d", rsp_status, want.status));
               if (rsp_removed_value !== want.removed)
                  report($sformatf("removed value %h, predicted %h",
                                   rsp_removed_value, want.removed));
               if (rsp_list_length !== want.length)
                  report($sformatf("length %0d, predicted %0d",
                                   rsp_list_length, want.length));
            end
         end
         if (start && !busy)
            predicted_outcomes.push_back(list_command(req_kind, req_position, req_item_value));
      end
      outstanding <= predicted_outcomes.size();
   end

endmodule

@@ bench/ordered_list_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_core_tb
// Drives command beats into the ordered list engine: a directed pass over
// empty and full lists, bad and oversized positions and undefined kinds,
// then random commands in alternating grow, shrink and mixed phases with
// random sender gaps. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module ordered_list_engine_core_tb
   import olst_pkg::*;
();

   localparam int                   RANDOM_ITEMS     = 900;
   localparam int                   CYCLE_LIMIT      = 200000;
   localparam int                   DRAIN_CYCLES     = 8;
   localparam int                   IDLE_PERCENT     = 13;
   localparam int                   QUIET_FIRST      = 400;
   localparam int                   QUIET_LAST       = 599;
   localparam int                   PHASE_ITEMS      = 40;
   localparam logic [KIND_BITS-1:0] KIND_UNDEF_FIRST = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_UNDEF_LAST  = 3'd7;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic        [KIND_BITS-1:0]   req_kind;
   logic        [POS_BITS-1:0]    req_position;
   logic signed [VALUE_BITS-1:0]  req_item_value;
   logic                          rsp_valid;
   logic        [STATUS_BITS-1:0] rsp_status;
   logic signed [VALUE_BITS-1:0]  rsp_removed_value;
   logic        [LEN_BITS-1:0]    rsp_list_length;
   int                            fail_count;
   int                            pending;
   int                            cycle_count;
   logic        [VALUE_BITS-1:0]  value_pool [8];

   ordered_list_engine_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_list_length   (rsp_list_length)
   );

   ordered_list_engine_core_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_list_length   (rsp_list_length),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // holds the beat until the engine takes it
   task automatic issue(input logic [KIND_BITS-1:0]  kind,
                        input logic [POS_BITS-1:0]   position,
                        input logic [VALUE_BITS-1:0] value);
      start          <= 1'b1;
      req_kind       <= kind;
      req_position   <= position;
      req_item_value <= value;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // pool values repeat often so that removes by value find matches
   function automatic logic [VALUE_BITS-1:0] pick_value(input int pool_percent);
      if ($urandom_range(99) < pool_percent)
         return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   initial begin
      int                    roll;
      int                    phase;
      logic [KIND_BITS-1:0]  kind;
      logic [POS_BITS-1:0]   position;
      logic [VALUE_BITS-1:0] value;

      reset          <= 1'b1;
      start          <= 1'b0;
      req_kind       <= KIND_INS_FRONT;
      req_position   <= '0;
      req_item_value <= '0;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++)
         value_pool[i] = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list, bad and oversized positions, duplicates, spare kinds
      issue(KIND_REM_FRONT, 8'h00, 32'h0000_0000);
      issue(KIND_REM_VALUE, 8'hff, 32'h8000_0000);
      issue(KIND_INS_POS, 8'h00, 32'h5555_5555);
      issue(KIND_INS_POS, 8'h05, 32'h1234_5678);
      issue(KIND_INS_FRONT, 8'hff, 32'h8000_0000);
      issue(KIND_APPEND, 8'h01, 32'h7fff_ffff);
      issue(KIND_INS_POS, 8'h02, 32'hffff_ffff);
      issue(KIND_INS_POS, 8'hff, 32'h1234_5678);
      issue(KIND_REM_VALUE, 8'h00, 32'h0bad_cafe);
      issue(KIND_REM_VALUE, 8'h00, 32'h1234_5678);
      issue(KIND_UNDEF_FIRST, 8'haa, 32'haaaa_aaaa);
      issue(KIND_UNDEF_FIRST + 3'd1, 8'h55, 32'h5555_5555);
      issue(KIND_UNDEF_LAST, 8'hff, 32'hffff_ffff);
      issue(KIND_REM_FRONT, 8'h00, 32'h0000_0000);
      // fill to capacity, then front and positioned inserts against the full list
      for (int i = 0; i < 13; i++)
         issue(KIND_APPEND, 8'(i + 1), $urandom);
      issue(KIND_INS_FRONT, 8'h00, 32'h0000_0001);
      issue(KIND_INS_POS, 8'h03, 32'h0000_0002);
      issue(KIND_INS_POS, 8'h00, 32'h0000_0003);
      issue(KIND_REM_VALUE, 8'h00, 32'h7fff_ffff);
      wait_for_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ((n < QUIET_FIRST || n > QUIET_LAST) && $urandom_range(99) < IDLE_PERCENT)
            idle($urandom_range(1, 5));
         if (n == 300 || n == 700)
            wait_for_results();
         phase = (n / PHASE_ITEMS) % 3;
         roll  = $urandom_range(99);
         if (roll < 4) begin
            kind = KIND_UNDEF_FIRST + 3'($urandom_range(2));
         end else if ((phase == 0 && roll < 72) || (phase == 1 && roll < 28) ||
                      (phase == 2 && roll < 52)) begin
            case ($urandom_range(2))
               0:       kind = KIND_INS_FRONT;
               1:       kind = KIND_APPEND;
               default: kind = KIND_INS_POS;
            endcase
         end else begin
            kind = ($urandom_range(1) == 0) ? KIND_REM_FRONT : KIND_REM_VALUE;
         end
         if ($urandom_range(3) == 0)
            position = POS_BITS'($urandom_range(255));
         else
            position = POS_BITS'($urandom_range(17));
         value = pick_value(kind == KIND_REM_VALUE ? 75 : 55);
         issue(kind, position, value);
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
design/olst_pkg.sv
design/olst_cell.sv
design/ordered_list_engine_core.sv
design/olst_checker.sv
bench/ordered_list_engine_core_checker.sv
bench/ordered_list_engine_core_tb.sv
